@@ src/ltgn_pkg.sv @@
// Shared constants, types and helpers for the label tuple group numbering block.
// No dependencies; every other file of the block depends on this package.
package ltgn_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int MAX_SOLUTIONS = 8;
	localparam int LABEL_BITS    = 4;

	localparam int TUPLE_W = 32;
	localparam int ID_W    = 8;
	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int SOLS_W     = 4;
	localparam logic [SOLS_W-1:0] SOLS_RESET = SOLS_W'(1);
	localparam logic REG_SOLS_IN_USE = 1'b0;

	localparam logic [ID_W-1:0] ID_OVERFLOW = {ID_W{1'b1}};

	// Search token that walks along the row of cells.
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [IDX_W-1:0] id;
	} token_t;

	// Store write request broadcast to the row of cells.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [TUPLE_W-1:0] data;
	} wr_req_t;

	// Mask over the labels that take part in matching; the count is clamped
	// to one at the low end and to the maximum number of solutions at the top.
	function automatic logic [TUPLE_W-1:0] tuple_mask(input logic [SOLS_W-1:0] sols);
		int unsigned n;
		int unsigned bits;
		n = int'(sols);
		if (n == 0)
			n = 1;
		if (n > MAX_SOLUTIONS)
			n = MAX_SOLUTIONS;
		bits = n * LABEL_BITS;
		if (bits >= TUPLE_W)
			return {TUPLE_W{1'b1}};
		return TUPLE_W'((64'd1 << bits) - 64'd1);
	endfunction

	function automatic logic [ID_W-1:0] to_group_id(input logic [CNT_W-1:0] value);
		logic [31:0] wide;
		wide = 32'(value);
		return wide[ID_W-1:0];
	endfunction

endpackage

@@ src/ltgn_ifs.sv @@
// Valid/ready channel interfaces for node items and numbering results.
// Depends on ltgn_pkg for field widths.
interface ltgn_in_if;
	logic                        valid;
	logic                        ready;
	logic [ltgn_pkg::TUPLE_W-1:0] part_labels;
	logic                        start_set;

	modport source (output valid, output part_labels, output start_set, input ready);
	modport sink (input valid, input part_labels, input start_set, output ready);
endinterface

interface ltgn_out_if;
	logic                     valid;
	logic                     ready;
	logic [ltgn_pkg::ID_W-1:0] group_id;
	logic                     new_group;
	logic                     overflow;

	modport source (output valid, output group_id, output new_group, output overflow,
		input ready);
	modport sink (input valid, input group_id, input new_group, input overflow,
		output ready);
endinterface

@@ src/ltgn_cell.sv @@
// One cell of the tuple store: holds one stored tuple and passes the search
// token to its neighbor every cycle. Depends on ltgn_pkg.
module ltgn_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ltgn_pkg::IDX_W-1:0]   cell_idx,
	input  logic [ltgn_pkg::CNT_W-1:0]   count,
	input  logic [ltgn_pkg::TUPLE_W-1:0] query,
	input  logic [ltgn_pkg::TUPLE_W-1:0] mask,
	input  ltgn_pkg::wr_req_t            wr,
	input  ltgn_pkg::token_t             tok_in,
	output ltgn_pkg::token_t             tok_out
);
	import ltgn_pkg::*;

	logic [TUPLE_W-1:0] tuple_q;
	token_t             tok_q;
	token_t             tok_d;
	logic               occupied;
	logic               match;

	// Only cells below the fill count hold a tuple of the current set.
	assign occupied = CNT_W'(cell_idx) < count;
	assign match    = occupied && ((tuple_q & mask) == query);

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx))
			tuple_q <= wr.data;
	end

	always_comb begin
		tok_d = tok_in;
		// The first hit along the row is the lowest index and wins.
		if (tok_in.valid && !tok_in.hit && match) begin
			tok_d.hit = 1'b1;
			tok_d.id  = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ src/ltgn_apb.sv @@
// APB-style configuration register file: holds the number of solutions in use.
// Depends on ltgn_pkg.
module ltgn_apb (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ltgn_pkg::ADDR_W-1:0]     paddr,
	input  logic [ltgn_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ltgn_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [ltgn_pkg::SOLS_W-1:0]     sols_in_use
);
	import ltgn_pkg::*;

	logic [SOLS_W-1:0] sols_q;
	logic              sel_sols;

	assign pready   = 1'b1;
	assign sel_sols = paddr[ADDR_W-1] == REG_SOLS_IN_USE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sols_q <= SOLS_RESET;
		end else if (psel && penable && pwrite && pready && sel_sols) begin
			sols_q <= pwdata[SOLS_W-1:0];
		end
	end

	assign prdata      = sel_sols ? CFG_DATA_W'(sols_q) : '0;
	assign sols_in_use = sols_q;

endmodule

@@ src/label_tuple_group_numbering.sv @@
// Label tuple group numbering: dense ids for distinct label tuples.
// Flow: an accepted item is searched by a token walking the full row of TABLE_DEPTH
// store cells, then resolved into a registered result; the resolve step waits while
// the output is held. One item is in the block at a time.
// Reset: clears the group count, the token row and the handshakes; sols_in_use
// becomes 1. Stored tuples are not cleared, since only filled cells ever match.
module label_tuple_group_numbering (
	input  logic                            clk,
	input  logic                            arst_n,
	ltgn_in_if.sink                         items,
	ltgn_out_if.source                      results,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ltgn_pkg::ADDR_W-1:0]     paddr,
	input  logic [ltgn_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ltgn_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import ltgn_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [TUPLE_W-1:0] query_q;
	logic [TUPLE_W-1:0] mask_q;
	logic               inject_q;
	logic               end_hit_q;
	logic [IDX_W-1:0]   end_id_q;

	logic               out_valid_q;
	logic [ID_W-1:0]    group_id_q;
	logic               new_group_q;
	logic               overflow_q;

	logic [SOLS_W-1:0]  sols_in_use;
	logic [TUPLE_W-1:0] cur_mask;
	logic               in_fire;
	logic               out_free;
	logic               resolve;
	logic               full;
	wr_req_t            wr;
	token_t             tok [TABLE_DEPTH+1];

	ltgn_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sols_in_use (sols_in_use)
	);

	assign cur_mask = tuple_mask(sols_in_use);

	assign items.ready = state_q == ST_IDLE;
	assign in_fire     = items.valid && items.ready;
	assign out_free    = !out_valid_q || results.ready;
	assign resolve     = (state_q == ST_DONE) && out_free;
	assign full        = count_q == CNT_W'(TABLE_DEPTH);

	// A new tuple is appended at the fill count when the search missed and the store has room.
	assign wr.en   = resolve && !end_hit_q && !full;
	assign wr.idx  = count_q[IDX_W-1:0];
	assign wr.data = query_q;

	assign tok[0] = '{valid: inject_q, hit: 1'b0, id: '0};

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		ltgn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.count    (count_q),
			.query    (query_q),
			.mask     (mask_q),
			.wr       (wr),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			query_q <= items.part_labels & cur_mask;
			mask_q  <= cur_mask;
		end
		if (tok[TABLE_DEPTH].valid) begin
			end_hit_q <= tok[TABLE_DEPTH].hit;
			end_id_q  <= tok[TABLE_DEPTH].id;
		end
		if (resolve) begin
			if (end_hit_q) begin
				group_id_q  <= to_group_id(CNT_W'(end_id_q));
				new_group_q <= 1'b0;
				overflow_q  <= 1'b0;
			end else if (full) begin
				group_id_q  <= ID_OVERFLOW;
				new_group_q <= 1'b0;
				overflow_q  <= 1'b1;
			end else begin
				group_id_q  <= to_group_id(count_q);
				new_group_q <= 1'b1;
				overflow_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			inject_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			inject_q <= in_fire;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SEARCH;
						if (items.start_set)
							count_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (tok[TABLE_DEPTH].valid)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (resolve) begin
						state_q <= ST_IDLE;
						if (wr.en)
							count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (resolve)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.group_id  = group_id_q;
	assign results.new_group = new_group_q;
	assign results.overflow  = overflow_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("group count beyond store depth");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(new_group_q && overflow_q))
		else $error("new group and overflow both set");

	a_overflow_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overflow_q) |-> (group_id_q == ID_OVERFLOW))
		else $error("overflow result without overflow id");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		inject_q |=> !inject_q)
		else $error("search token launched twice");

	a_accept_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SEARCH) && inject_q)
		else $error("accepted transaction did not start a search");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for label_tuple_group_numbering: node label tuples go in and
// dense group ids come back, each checked against a behavioral numbering model kept here.
// Depends on ltgn_pkg and the ltgn_in_if / ltgn_out_if channel interfaces.
`timescale 1ns / 1ps

module tb;
	import ltgn_pkg::*;

	localparam int REG_SOLS  = int'(REG_SOLS_IN_USE);
	localparam int REG_SPARE = REG_SOLS + 1;
	localparam int N_DIRECTED = 20;
	localparam int N_PHASES   = 12;

	typedef struct packed {
		logic [ID_W-1:0] group_id;
		logic            new_group;
		logic            overflow;
	} group_res_t;

	typedef struct packed {
		logic               cfg_en;
		logic [1:0]         cfg_reg;
		logic [SOLS_W-1:0]  cfg_val;
		logic [TUPLE_W-1:0] labels;
		logic               start;
		logic               typed;
		logic [ID_W-1:0]    id;
		logic               new_g;
		logic               ovf;
	} step_row_t;

	typedef struct packed {
		logic [SOLS_W-1:0] sols;
		logic              fresh;
		logic              noisy;
		logic [10:0]       count;
		logic [6:0]        pct_new;
	} phase_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_TIGHT} sink_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	ltgn_in_if  item_bus ();
	ltgn_out_if result_bus ();

	label_tuple_group_numbering u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Model state of the numbering store.
	logic [TUPLE_W-1:0] tuple_store [TABLE_DEPTH];
	int unsigned        group_count = 0;
	logic [SOLS_W-1:0]  sols_in_use = SOLS_RESET;

	group_res_t expected_groups [$];
	int failures = 0;
	int burst_left = 0;

	sink_mode_e sink_mode = SINK_OPEN;
	int sink_phase_left = 0;

	// Directed steps. Rows with typed = 1 carry a hand-computed result; the others
	// (overlapping matches after a mask change, saturated counts) rely on the model.
	step_row_t directed_steps [N_DIRECTED] = '{
		'{1'b0, 2'd0, 4'd0, 32'h0000_0000, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'hFFFF_FFF0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_000F, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd1, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h1234_5675, 1'b0, 1'b1, 8'd2, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_0005, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_000F, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'hABCD_EF05, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
		'{1'b1, 2'(REG_SOLS), 4'd8, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
		'{1'b1, 2'(REG_SOLS), 4'd0, 32'h0000_000F, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_0003, 1'b0, 1'b1, 8'd2, 1'b1, 1'b0},
		'{1'b1, 2'(REG_SOLS), 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_0003, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},
		'{1'b1, 2'(REG_SOLS), 4'd2, 32'h0000_0000, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b0, 2'd0, 4'd0, 32'h0000_00AB, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0},
		'{1'b1, 2'(REG_SPARE), 4'd8, 32'h1234_56AB, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
		'{1'b1, 2'(REG_SOLS), 4'd9, 32'h0000_00AB, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}
	};

	// Random phases: the count setting, whether the set starts empty, whether stray
	// starts break the set, item count and the share of fresh tuples in percent.
	// The third phase fills the store and runs into overflow; the one after it narrows
	// the mask over the full store without a start.
	phase_t test_phases [N_PHASES] = '{
		'{4'd1,  1'b1, 1'b1, 11'd150, 7'd40},
		'{4'd0,  1'b1, 1'b1, 11'd100, 7'd40},
		'{4'd8,  1'b1, 1'b0, 11'd300, 7'd95},
		'{4'd2,  1'b0, 1'b1, 11'd120, 7'd50},
		'{4'd15, 1'b1, 1'b1, 11'd150, 7'd50},
		'{4'd3,  1'b1, 1'b1, 11'd150, 7'd60},
		'{4'd9,  1'b0, 1'b1, 11'd100, 7'd40},
		'{4'd4,  1'b1, 1'b1, 11'd150, 7'd50},
		'{4'd5,  1'b1, 1'b1, 11'd120, 7'd50},
		'{4'd6,  1'b1, 1'b1, 11'd120, 7'd50},
		'{4'd7,  1'b1, 1'b1, 11'd120, 7'd50},
		'{4'd10, 1'b1, 1'b1, 11'd120, 7'd50}
	};

	function automatic logic [TUPLE_W-1:0] label_mask(input logic [SOLS_W-1:0] sols);
		int unsigned n;
		int unsigned bits;
		n = int'(sols);
		if (n == 0)
			n = 1;
		if (n > MAX_SOLUTIONS)
			n = MAX_SOLUTIONS;
		bits = n * LABEL_BITS;
		if (bits >= TUPLE_W)
			return '1;
		return (TUPLE_W'(1) << bits) - TUPLE_W'(1);
	endfunction

	// Numbers one node and updates the model store.
	function automatic group_res_t number_tuple(input logic [TUPLE_W-1:0] labels,
		input logic start);
		logic [TUPLE_W-1:0] mask;
		logic [TUPLE_W-1:0] key;
		group_res_t res;
		bit hit;
		int idx;
		mask = label_mask(sols_in_use);
		key = labels & mask;
		if (start)
			group_count = 0;
		hit = 1'b0;
		idx = 0;
		for (int i = 0; i < int'(group_count) && !hit; i++) begin
			if ((tuple_store[i] & mask) == key) begin
				hit = 1'b1;
				idx = i;
			end
		end
		if (hit) begin
			res = '{ID_W'(idx), 1'b0, 1'b0};
		end else if (group_count >= TABLE_DEPTH) begin
			res = '{ID_OVERFLOW, 1'b0, 1'b1};
		end else begin
			tuple_store[group_count] = key;
			res = '{ID_W'(group_count), 1'b1, 1'b0};
			group_count++;
		end
		return res;
	endfunction

	// Either fresh random labels or a stored tuple with random bits outside the mask.
	function automatic logic [TUPLE_W-1:0] make_labels(input int pct_new);
		logic [TUPLE_W-1:0] mask;
		logic [TUPLE_W-1:0] noise;
		mask = label_mask(sols_in_use);
		noise = $urandom();
		if (group_count == 0 || $urandom_range(0, 99) < pct_new)
			return noise;
		return (tuple_store[$urandom_range(0, group_count - 1)] & mask) | (noise & ~mask);
	endfunction

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_bus.valid <= 1'b0;
			if ($urandom_range(0, 15) == 0)
				repeat ($urandom_range(1, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 40);
		end
	endtask

	task automatic send_item(input logic [TUPLE_W-1:0] labels, input logic start,
		input bit typed, input group_res_t typed_res);
		group_res_t res;
		group_res_t queued;
		item_bus.valid <= 1'b1;
		item_bus.part_labels <= labels;
		item_bus.start_set <= start;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		res = number_tuple(labels, start);
		queued = typed ? typed_res : res;
		expected_groups.insert(expected_groups.size(), queued);
		pace_sender();
	endtask

	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		while (expected_groups.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [SOLS_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= {28'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// Only the first register exists; a write to the spare index is dropped.
		if (idx == REG_SOLS)
			sols_in_use = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Result sink: switches between always ready, random chop and long stalls.
	always @(posedge clk) begin
		if (sink_phase_left == 0) begin
			sink_mode <= sink_mode_e'($urandom_range(0, 2));
			sink_phase_left <= $urandom_range(50, 600);
		end else begin
			sink_phase_left <= sink_phase_left - 1;
		end
		case (sink_mode)
			SINK_OPEN: result_bus.ready <= 1'b1;
			SINK_CHOPPY: result_bus.ready <= 1'($urandom_range(0, 1));
			default: result_bus.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		group_res_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_groups.size() == 0) begin
				$error("result transaction with no expected group pending");
				failures++;
			end else begin
				want = expected_groups.pop_front();
				if (result_bus.group_id !== want.group_id) begin
					$error("group_id: expected %0d, got %0d", want.group_id,
						result_bus.group_id);
					failures++;
				end
				if (result_bus.new_group !== want.new_group) begin
					$error("new_group: expected %0b, got %0b", want.new_group,
						result_bus.new_group);
					failures++;
				end
				if (result_bus.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow,
						result_bus.overflow);
					failures++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("label_tuple_group_numbering test failed");
		$finish;
	end

	initial begin
		step_row_t row;
		phase_t ph;
		logic start_bit;
		item_bus.valid = 1'b0;
		item_bus.part_labels = '0;
		item_bus.start_set = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run with the count setting left at its reset value.
		for (int r = 0; r < N_DIRECTED; r++) begin
			row = directed_steps[r];
			if (row.cfg_en) begin
				wait_idle();
				write_reg(int'(row.cfg_reg), row.cfg_val);
			end
			send_item(row.labels, row.start, row.typed, '{row.id, row.new_g, row.ovf});
		end

		for (int p = 0; p < N_PHASES; p++) begin
			ph = test_phases[p];
			wait_idle();
			write_reg(REG_SOLS, ph.sols);
			for (int k = 0; k < int'(ph.count); k++) begin
				if (k == 0)
					start_bit = ph.fresh;
				else
					start_bit = ph.noisy && ($urandom_range(0, 49) == 0);
				send_item(make_labels(int'(ph.pct_new)), start_bit, 1'b0, '0);
			end
		end

		wait_idle();
		// Let a full search pass go by so that a spurious extra result would show up.
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (failures == 0)
			$display("label_tuple_group_numbering test passed");
		else
			$display("label_tuple_group_numbering test failed");
		$finish;
	end

endmodule
